### design/cfmq_pkg.sv
// Package for the CAN frame multi-queue block: sizes, codes, frame type and
// pointer helpers. No dependencies.
package cfmq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int NUM_QUEUES  = 4;
	localparam int PTR_W       = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int MEM_DEPTH   = NUM_QUEUES * QUEUE_DEPTH;
	localparam int ADDR_W      = $clog2(MEM_DEPTH);
	localparam int CNT_W       = 8;
	localparam int QSEL_W      = 2;

	localparam logic [1:0] ALL_MAILBOXES = 2'd3;

	typedef logic [PTR_W-1:0]  ptr_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [QSEL_W-1:0] qsel_t;

	typedef enum logic [1:0] {
		FUNC_PUSH = 2'd0,
		FUNC_POP  = 2'd1,
		FUNC_LEN  = 2'd2,
		FUNC_TX   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_IGNORED = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_READ
	} state_t;

	typedef struct packed {
		logic [63:0] data;
		logic [3:0]  dlc;
		logic        rtr;
		logic        ext;
		logic [28:0] id;
	} frame_t;

	// One write and one read per cycle into the frame store
	typedef struct packed {
		logic   we;
		addr_t  waddr;
		frame_t wdata;
		logic   re;
		addr_t  raddr;
	} mem_req_t;

	function automatic ptr_t ptr_advance(input ptr_t p);
		ptr_t r;
		if (p == ptr_t'(QUEUE_DEPTH - 1))
			r = '0;
		else
			r = p + ptr_t'(1);
		return r;
	endfunction

	function automatic logic [CNT_W-1:0] queue_len(input ptr_t h, input ptr_t t);
		logic [CNT_W-1:0] r;
		if (h >= t)
			r = CNT_W'(h) - CNT_W'(t);
		else
			r = CNT_W'(QUEUE_DEPTH) - CNT_W'(t) + CNT_W'(h);
		return r;
	endfunction

	function automatic addr_t slot_addr(input qsel_t q, input ptr_t p);
		return addr_t'(q) * addr_t'(QUEUE_DEPTH) + addr_t'(p);
	endfunction

endpackage

### design/can_frame_multi_queue_core.sv
// Top level of the CAN frame multi-queue block: four ring queues (rx and tx
// of two channels) over one frame RAM. Depends on cfmq_pkg and cfmq_store.
//
// Usage:
//   Requests come in on the in_valid/in_ready channel (func, channel,
//   direction, frame fields, mailboxes_free). Each request gives exactly one
//   result on the out_valid/out_ready channel: status, count, and a frame
//   when frame_valid is high (transmit tells a mailbox handoff from a pop).
//   A push also tries to send the head of the channel's tx queue.
//   A request is taken into the S_READ state and the stage-1 registers while
//   the frame RAM read runs; the result then goes into the output register,
//   where out_valid rises. A new request is not taken until the block is back
//   in S_IDLE, so one request is handled at a time.
//   A request may be taken while the previous result waits, as long as that
//   result transfers in the same cycle; if the receiver stalls, in_ready
//   stays low until the output register is free.
//   Reset clears all queue pointers, so every queue starts empty. The frame
//   RAM is not cleared; a slot is only read after it has been written.
module can_frame_multi_queue_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [1:0]  channel,
	input  logic        direction,
	input  logic [28:0] frame_id,
	input  logic        frame_ext,
	input  logic        frame_rtr,
	input  logic [3:0]  frame_dlc,
	input  logic [63:0] frame_data,
	input  logic [1:0]  mailboxes_free,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [7:0]  count,
	output logic        frame_valid,
	output logic        transmit,
	output logic [28:0] out_id,
	output logic        out_ext,
	output logic        out_rtr,
	output logic [3:0]  out_dlc,
	output logic [63:0] out_data
);
	import cfmq_pkg::*;

	state_t state_q, state_d;

	ptr_t wr_ptr_q [NUM_QUEUES];
	ptr_t rd_ptr_q [NUM_QUEUES];

	logic accept;
	logic ignored;
	func_t fn;
	qsel_t q, txq;
	ptr_t h, t, nh, tx_wp, tx_rp;
	logic full, push_ok, pop_ok, tx_nonempty, send;
	status_t st;
	logic [CNT_W-1:0] cnt;
	mem_req_t req;
	frame_t rd_frame;

	status_t          status_s1;
	logic [CNT_W-1:0] count_s1;
	logic             frame_s1;
	logic             transmit_s1;

	logic             out_valid_q;
	status_t          status_q;
	logic [CNT_W-1:0] count_q;
	logic             frame_valid_q;
	logic             transmit_q;
	frame_t           frame_q;

	assign in_ready = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;

	// request decode
	always_comb begin
		fn          = func_t'(func);
		ignored     = channel[1];
		q           = {direction, channel[0]};
		txq         = {1'b1, channel[0]};
		h           = wr_ptr_q[q];
		t           = rd_ptr_q[q];
		nh          = ptr_advance(h);
		full        = (nh == t);
		push_ok     = (fn == FUNC_PUSH) && !full;
		pop_ok      = (fn == FUNC_POP) && (h != t);
		tx_wp       = (push_ok && direction) ? nh : wr_ptr_q[txq];
		tx_rp       = rd_ptr_q[txq];
		tx_nonempty = (tx_wp != tx_rp);
		send        = ((fn == FUNC_PUSH) || (fn == FUNC_TX)) && tx_nonempty &&
			(mailboxes_free == ALL_MAILBOXES) && !ignored;
		cnt         = '0;
		unique case (fn)
			FUNC_PUSH: st = full ? ST_FULL : ST_OK;
			FUNC_POP:  st = pop_ok ? ST_OK : ST_EMPTY;
			FUNC_LEN: begin
				st  = ST_OK;
				cnt = queue_len(h, t);
			end
			FUNC_TX:   st = tx_nonempty ? ST_OK : ST_EMPTY;
			default:   st = ST_OK;
		endcase
		if (ignored) begin
			st  = ST_IGNORED;
			cnt = '0;
		end
	end

	always_comb begin
		req.we    = accept && !ignored && push_ok;
		req.waddr = slot_addr(q, h);
		req.wdata = '{data: frame_data, dlc: frame_dlc, rtr: frame_rtr,
			ext: frame_ext, id: frame_id};
		req.re    = accept && !ignored && (send || pop_ok);
		req.raddr = send ? slot_addr(txq, tx_rp) : slot_addr(q, t);
	end

	cfmq_store u_store (
		.clk      (clk),
		.req      (req),
		.rd_frame (rd_frame)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				wr_ptr_q[i] <= '0;
				rd_ptr_q[i] <= '0;
			end
		end else if (accept && !ignored) begin
			if (push_ok)
				wr_ptr_q[q] <= nh;
			if (pop_ok)
				rd_ptr_q[q] <= ptr_advance(t);
			if (send)
				rd_ptr_q[txq] <= ptr_advance(tx_rp);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (accept) state_d = S_READ;
			S_READ:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1   <= st;
			count_s1    <= cnt;
			frame_s1    <= !ignored && (send || pop_ok);
			transmit_s1 <= !ignored && send;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == S_READ)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_READ) begin
			status_q      <= status_s1;
			count_q       <= count_s1;
			frame_valid_q <= frame_s1;
			transmit_q    <= transmit_s1;
			frame_q       <= frame_s1 ? rd_frame : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign count       = count_q;
	assign frame_valid = frame_valid_q;
	assign transmit    = transmit_q;
	assign out_id      = frame_q.id;
	assign out_ext     = frame_q.ext;
	assign out_rtr     = frame_q.rtr;
	assign out_dlc     = frame_q.dlc;
	assign out_data    = frame_q.data;

endmodule

### design/cfmq_store.sv
// Frame store for all four queues: one synchronous RAM, read data in the cycle
// after the request, with write-to-read bypass. Depends on cfmq_pkg.
module cfmq_store (
	input  logic               clk,
	input  cfmq_pkg::mem_req_t req,
	output cfmq_pkg::frame_t   rd_frame
);
	import cfmq_pkg::*;

	frame_t mem [MEM_DEPTH];
	frame_t rd_q;
	frame_t byp_q;
	logic   fwd_q;

	always_ff @(posedge clk) begin
		if (req.we)
			mem[req.waddr] <= req.wdata;
		if (req.re)
			rd_q <= mem[req.raddr];
		// same-cycle write and read of one slot: hand back the new frame
		fwd_q <= req.we && req.re && (req.waddr == req.raddr);
		byp_q <= req.wdata;
	end

	assign rd_frame = fwd_q ? byp_q : rd_q;

endmodule

### verif/tb_can_frame_multi_queue_core.sv
// Testbench for can_frame_multi_queue_core: random and directed queue ops with
// idle bursts on both sides, checked against a cycle-free model of the four queues.
// Depends on cfmq_pkg and the design sources.
module tb_can_frame_multi_queue_core;
	import cfmq_pkg::*;

	localparam int TOTAL_OPS = 1475;

	typedef struct packed {
		logic       drain_first;
		func_t      func;
		logic [1:0] channel;
		logic       direction;
		frame_t     frame;
		logic [1:0] mailboxes;
	} queue_op_t;

	typedef struct packed {
		status_t    status;
		logic [7:0] count;
		logic       frame_valid;
		logic       transmit;
		frame_t     frame;
	} queue_reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  func = '0;
	logic [1:0]  channel = '0;
	logic        direction = 1'b0;
	logic [28:0] frame_id = '0;
	logic        frame_ext = 1'b0;
	logic        frame_rtr = 1'b0;
	logic [3:0]  frame_dlc = '0;
	logic [63:0] frame_data = '0;
	logic [1:0]  mailboxes_free = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  status;
	logic [7:0]  count;
	logic        frame_valid;
	logic        transmit;
	logic [28:0] out_id;
	logic        out_ext;
	logic        out_rtr;
	logic [3:0]  out_dlc;
	logic [63:0] out_data;

	can_frame_multi_queue_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.func           (func),
		.channel        (channel),
		.direction      (direction),
		.frame_id       (frame_id),
		.frame_ext      (frame_ext),
		.frame_rtr      (frame_rtr),
		.frame_dlc      (frame_dlc),
		.frame_data     (frame_data),
		.mailboxes_free (mailboxes_free),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.count          (count),
		.frame_valid    (frame_valid),
		.transmit       (transmit),
		.out_id         (out_id),
		.out_ext        (out_ext),
		.out_rtr        (out_rtr),
		.out_dlc        (out_dlc),
		.out_data       (out_data)
	);

	always #2 clk = ~clk;

	// queue contents as the block should hold them
	frame_t slot_frame [NUM_QUEUES][QUEUE_DEPTH];
	int     wr_idx [NUM_QUEUES];
	int     rd_idx [NUM_QUEUES];

	queue_op_t    ops_to_send[$];
	queue_reply_t replies_due[$];

	int ops_accepted = 0;
	int replies_seen = 0;
	int mismatches = 0;
	int cycle_no = 0;
	bit quiet = 1'b0;
	bit drain_next = 1'b0;

	always @(posedge clk) cycle_no <= cycle_no + 1;

	function automatic int next_slot(int p);
		return (p + 1 >= QUEUE_DEPTH) ? 0 : p + 1;
	endfunction

	function automatic int fill_level(int q);
		if (wr_idx[q] >= rd_idx[q])
			return wr_idx[q] - rd_idx[q];
		return QUEUE_DEPTH - rd_idx[q] + wr_idx[q];
	endfunction

	function automatic void take_head(int q, logic tx, inout queue_reply_t r);
		r.frame_valid = 1'b1;
		r.transmit = tx;
		r.frame = slot_frame[q][rd_idx[q]];
		rd_idx[q] = next_slot(rd_idx[q]);
	endfunction

	// tx queue of the channel goes out only with all mailboxes free
	function automatic void try_mailbox(int ch, logic [1:0] mb, inout queue_reply_t r);
		if (fill_level(2 + ch) != 0 && mb == ALL_MAILBOXES)
			take_head(2 + ch, 1'b1, r);
	endfunction

	function automatic queue_reply_t apply_op(queue_op_t op);
		queue_reply_t r;
		int q;
		int ch;
		int nxt;
		r = '0;
		if (op.channel > 2'd1) begin
			r.status = ST_IGNORED;
			return r;
		end
		ch = int'(op.channel);
		q = int'(op.direction) * 2 + ch;
		case (op.func)
			FUNC_PUSH: begin
				nxt = next_slot(wr_idx[q]);
				if (nxt != rd_idx[q]) begin
					slot_frame[q][wr_idx[q]] = op.frame;
					wr_idx[q] = nxt;
					r.status = ST_OK;
				end else begin
					r.status = ST_FULL;
				end
				try_mailbox(ch, op.mailboxes, r);
			end
			FUNC_POP: begin
				if (fill_level(q) != 0) begin
					take_head(q, 1'b0, r);
					r.status = ST_OK;
				end else begin
					r.status = ST_EMPTY;
				end
			end
			FUNC_LEN: begin
				r.status = ST_OK;
				r.count = 8'(fill_level(q));
			end
			default: begin
				if (fill_level(2 + ch) == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.status = ST_OK;
					try_mailbox(ch, op.mailboxes, r);
				end
			end
		endcase
		return r;
	endfunction

	function automatic queue_op_t rand_op(func_t f, int ch, int dir, int mb);
		queue_op_t op;
		op.drain_first = 1'b0;
		op.func = f;
		op.channel = 2'(ch);
		op.direction = 1'(dir);
		op.frame.id = 29'($urandom);
		op.frame.ext = 1'($urandom);
		op.frame.rtr = 1'($urandom);
		op.frame.dlc = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15))
			: 4'($urandom_range(0, 8));
		op.frame.data = {$urandom, $urandom};
		op.mailboxes = 2'(mb);
		return op;
	endfunction

	function automatic int busy_mb();
		return ($urandom_range(0, 5) == 0) ? 3 : $urandom_range(0, 2);
	endfunction

	function automatic int pick_channel();
		return ($urandom_range(0, 15) == 0) ? $urandom_range(2, 3) : $urandom_range(0, 1);
	endfunction

	task automatic add_op(queue_op_t op);
		if (drain_next) begin
			op.drain_first = 1'b1;
			drain_next = 1'b0;
		end
		ops_to_send.push_back(op);
	endtask

	// ---------------- driver ----------------
	queue_op_t cur_op;
	queue_op_t head_op;
	int        send_gap = 0;
	bit        next_valid;

	always @(posedge clk) begin
		if (arst_n) begin
			next_valid = in_valid;
			if (in_valid && in_ready) begin
				replies_due.push_back(apply_op(cur_op));
				ops_accepted++;
				next_valid = 1'b0;
				if (!quiet && ((cycle_no >> 7) & 3) != 3 && $urandom_range(0, 4) == 0)
					send_gap = $urandom_range(1, 15);
			end
			if (!next_valid) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (ops_to_send.size() != 0) begin
					head_op = ops_to_send[0];
					// a marked op waits until every reply is back
					if (!(head_op.drain_first && replies_due.size() != 0)) begin
						cur_op = ops_to_send.pop_front();
						next_valid = 1'b1;
						func <= cur_op.func;
						channel <= cur_op.channel;
						direction <= cur_op.direction;
						frame_id <= cur_op.frame.id;
						frame_ext <= cur_op.frame.ext;
						frame_rtr <= cur_op.frame.rtr;
						frame_dlc <= cur_op.frame.dlc;
						frame_data <= cur_op.frame.data;
						mailboxes_free <= cur_op.mailboxes;
					end
				end
			end
			quiet = ops_to_send.size() < 150;
			in_valid <= next_valid;
		end
	end

	// ---------------- monitor ----------------
	queue_reply_t got;
	queue_reply_t want;
	int           ready_gap = 0;
	int           hold_left = 0;
	bit           hold_done = 1'b0;
	bit           next_ready;

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got.status = status_t'(status);
				got.count = count;
				got.frame_valid = frame_valid;
				got.transmit = transmit;
				got.frame.id = out_id;
				got.frame.ext = out_ext;
				got.frame.rtr = out_rtr;
				got.frame.dlc = out_dlc;
				got.frame.data = out_data;
				replies_seen++;
				if (replies_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("reply %0d: transfer with no op outstanding (status %0d)",
							replies_seen, status);
				end else begin
					want = replies_due.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("reply %0d exp: st=%0d cnt=%0d fv=%b tx=%b id=%h ext=%b rtr=%b dlc=%0d data=%h",
								replies_seen, want.status, want.count, want.frame_valid,
								want.transmit, want.frame.id, want.frame.ext,
								want.frame.rtr, want.frame.dlc, want.frame.data);
							$display("reply %0d got: st=%0d cnt=%0d fv=%b tx=%b id=%h ext=%b rtr=%b dlc=%0d data=%h",
								replies_seen, got.status, got.count, got.frame_valid,
								got.transmit, got.frame.id, got.frame.ext,
								got.frame.rtr, got.frame.dlc, got.frame.data);
						end
					end
				end
			end
			next_ready = 1'b1;
			if (hold_left > 0) begin
				hold_left--;
				next_ready = 1'b0;
			end else if (!hold_done && replies_seen >= 300) begin
				// long back-pressure: the block must fill and drop in_ready
				hold_done = 1'b1;
				hold_left = 400;
				next_ready = 1'b0;
			end else if (ready_gap > 0) begin
				ready_gap--;
				next_ready = 1'b0;
			end else if (!quiet && ((cycle_no >> 7) & 3) != 1 && $urandom_range(0, 5) == 0) begin
				ready_gap = $urandom_range(1, 15) - 1;
				next_ready = 1'b0;
			end
			out_ready <= next_ready;
		end
	end

	// ---------------- stimulus and end of run ----------------
	initial begin
		queue_op_t op;
		int kind;
		int ch;
		int dir;
		int n;

		for (int q = 0; q < NUM_QUEUES; q++) begin
			wr_idx[q] = 0;
			rd_idx[q] = 0;
		end

		// empty queues
		add_op(rand_op(FUNC_LEN, 0, 0, 0));
		add_op(rand_op(FUNC_POP, 0, 0, 3));
		add_op(rand_op(FUNC_TX, 0, 1, 3));
		add_op(rand_op(FUNC_TX, 1, 0, 0));
		// field extremes through the rx queue
		op = rand_op(FUNC_PUSH, 0, 0, 0);
		op.frame = '1;
		add_op(op);
		op = rand_op(FUNC_PUSH, 0, 0, 3);
		op.frame = '0;
		add_op(op);
		add_op(rand_op(FUNC_POP, 0, 0, 1));
		add_op(rand_op(FUNC_POP, 0, 0, 2));
		// tx queue: held while mailboxes busy, sent when all free
		add_op(rand_op(FUNC_PUSH, 0, 1, 2));
		add_op(rand_op(FUNC_PUSH, 0, 1, 1));
		add_op(rand_op(FUNC_LEN, 0, 1, 3));
		add_op(rand_op(FUNC_TX, 0, 0, 0));
		add_op(rand_op(FUNC_TX, 0, 1, 3));
		add_op(rand_op(FUNC_PUSH, 1, 1, 3));
		add_op(rand_op(FUNC_PUSH, 0, 0, 3));
		add_op(rand_op(FUNC_LEN, 0, 1, 0));
		// channels above 1
		add_op(rand_op(FUNC_PUSH, 2, 0, 3));
		add_op(rand_op(FUNC_POP, 3, 1, 3));
		add_op(rand_op(FUNC_LEN, 2, 1, 0));
		add_op(rand_op(FUNC_TX, 3, 0, 3));
		add_op(rand_op(FUNC_PUSH, 1, 0, 0));
		add_op(rand_op(FUNC_POP, 1, 0, 3));
		add_op(rand_op(FUNC_POP, 1, 1, 3));

		drain_next = 1'b1;
		while (ops_to_send.size() < TOTAL_OPS) begin
			if (ops_to_send.size() >= 700 && ops_to_send.size() < 720)
				drain_next = 1'b1;
			kind = $urandom_range(0, 9);
			ch = pick_channel();
			dir = $urandom_range(0, 1);
			if (kind <= 2) begin
				// fill run, often long enough to hit a full queue
				n = $urandom_range(8, 20);
				repeat (n) add_op(rand_op(FUNC_PUSH, ch, dir, busy_mb()));
			end else if (kind <= 4) begin
				n = $urandom_range(4, 18);
				repeat (n) begin
					if ($urandom_range(0, 1) == 0)
						add_op(rand_op(FUNC_POP, ch, dir, $urandom_range(0, 3)));
					else
						add_op(rand_op(FUNC_TX, ch, dir,
							($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : 3));
				end
			end else if (kind <= 8) begin
				n = $urandom_range(1, 6);
				repeat (n)
					add_op(rand_op(func_t'($urandom_range(0, 3)), pick_channel(),
						$urandom_range(0, 1),
						($urandom_range(0, 1) == 0) ? 3 : $urandom_range(0, 3)));
			end else begin
				for (int q = 0; q < NUM_QUEUES; q++)
					add_op(rand_op(FUNC_LEN, q % 2, q / 2, $urandom_range(0, 3)));
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (ops_accepted < TOTAL_OPS || ops_to_send.size() != 0)
			@(posedge clk);
		while (replies_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0 && replies_due.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

endmodule

### can_frame_multi_queue_core.f
design/cfmq_pkg.sv
design/cfmq_store.sv
design/can_frame_multi_queue_core.sv
verif/tb_can_frame_multi_queue_core.sv
